// ----- rtl/box_mean_filter_3x3_core_macros.svh -----
// Assertion helpers used by the RTL controller.
`ifndef BOX_MEAN_FILTER_3X3_CORE_MACROS_SVH
`define BOX_MEAN_FILTER_3X3_CORE_MACROS_SVH

// Same-cycle implication, masked during reset.
`define BMF_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, masked during reset.
`define BMF_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/bmf_pkg.sv -----
`default_nettype none

package bmf_pkg;

    localparam int SIDE   = 8;
    localparam int PIXELS = SIDE * SIDE;
    localparam int AW     = $clog2(PIXELS);
    localparam int CW     = $clog2(SIDE);

    localparam int PIX_W     = 8;
    localparam int MEAN_W    = 16;
    localparam int FRAC_BITS = 8;
    localparam int SUM_W     = $clog2(9 * 255 + 1);

    // floor(x / d) == (x * ceil(2^S / d)) >> S for every x below 2^20
    localparam int RECIP_SHIFT = 24;
    localparam int RECIP_W     = 23;
    localparam int PROD_W      = SUM_W + RECIP_W;
    localparam int RECIP_4     = (2 ** RECIP_SHIFT + 3) / 4;
    localparam int RECIP_6     = (2 ** RECIP_SHIFT + 5) / 6;
    localparam int RECIP_9     = (2 ** RECIP_SHIFT + 8) / 9;

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_READ,
        ST_WAIT,
        ST_DIV,
        ST_EMIT
    } state_t;

    typedef enum logic [1:0] {
        DIV_BY_4,
        DIV_BY_6,
        DIV_BY_9
    } div_sel_t;

    typedef struct packed {
        logic     clr;
        logic     add;
        logic     mul;
        div_sel_t sel;
    } ctrl_t;

    function automatic logic [RECIP_W-1:0] recip(input div_sel_t sel);
        logic [RECIP_W-1:0] m;
        unique case (sel)
            DIV_BY_4: m = RECIP_W'(RECIP_4);
            DIV_BY_6: m = RECIP_W'(RECIP_6);
            DIV_BY_9: m = RECIP_W'(RECIP_9);
            default:  m = RECIP_W'(RECIP_9);
        endcase
        return m;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/bmf_store.sv -----
`default_nettype none

module bmf_store
    import bmf_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [PIX_W-1:0] wdata,
    input  wire logic             re,
    input  wire logic [AW-1:0]    raddr,
    output logic      [PIX_W-1:0] rdata
);

    logic [PIX_W-1:0] mem [PIXELS];
    logic [PIX_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ----- rtl/bmf_mean_unit.sv -----
`default_nettype none

module bmf_mean_unit
    import bmf_pkg::*;
(
    input  wire logic              clk,
    input  wire ctrl_t             ctrl,
    input  wire logic [PIX_W-1:0]  rd_data,
    output logic      [MEAN_W-1:0] mean
);

    logic [SUM_W-1:0]  acc_reg;
    logic [SUM_W-1:0]  acc_next;
    logic [PROD_W-1:0] prod_reg;
    logic [PROD_W-1:0] prod_next;

    always_comb
    begin
        priority if (ctrl.clr)
        begin
            acc_next = '0;
        end
        else if (ctrl.add)
        begin
            acc_next = acc_reg + SUM_W'(rd_data);
        end
        else
        begin
            acc_next = acc_reg;
        end
    end

    // sum * 256 / count, the 8-bit scale folded into the shift
    assign prod_next = PROD_W'(acc_reg) * PROD_W'(recip(ctrl.sel));

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        if (ctrl.mul)
        begin
            prod_reg <= prod_next;
        end
    end

    assign mean = prod_reg[RECIP_SHIFT-FRAC_BITS +: MEAN_W];

endmodule

`default_nettype wire

// ----- rtl/bmf_ctrl.sv -----
`default_nettype none
`include "box_mean_filter_3x3_core_macros.svh"

module bmf_ctrl
    import bmf_pkg::*;
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          accept,
    output logic               busy,
    output logic      [AW-1:0] waddr,
    output logic               rd_en,
    output logic      [AW-1:0] raddr,
    output ctrl_t              ctrl,
    output logic               valid,
    output logic               last
);

    state_t state_reg;
    state_t state_next;

    logic [AW-1:0] load_cnt_reg;
    logic [AW-1:0] load_cnt_next;
    logic [CW-1:0] row_reg;
    logic [CW-1:0] row_next;
    logic [CW-1:0] col_reg;
    logic [CW-1:0] col_next;
    logic [1:0]    dr_reg;
    logic [1:0]    dr_next;
    logic [1:0]    dc_reg;
    logic [1:0]    dc_next;
    logic          add_reg;
    logic          add_next;

    logic          tap_last;
    logic          load_last;
    logic          pix_last;
    logic [CW:0]   tap_row;
    logic [CW:0]   tap_col;
    logic          tap_inb;
    logic          row_edge;
    logic          col_edge;

    assign tap_last  = (dr_reg == 2'd2) && (dc_reg == 2'd2);
    assign load_last = (load_cnt_reg == AW'(PIXELS - 1));
    assign pix_last  = (row_reg == CW'(SIDE - 1)) && (col_reg == CW'(SIDE - 1));

    // window tap is offset by one: tap_row == 0 means row -1
    assign tap_row = (CW+1)'(row_reg) + (CW+1)'(dr_reg);
    assign tap_col = (CW+1)'(col_reg) + (CW+1)'(dc_reg);
    assign tap_inb = (tap_row != '0) && (tap_row <= (CW+1)'(SIDE))
                  && (tap_col != '0) && (tap_col <= (CW+1)'(SIDE));
    assign raddr   = AW'(tap_row - 1'b1) * AW'(SIDE) + AW'(tap_col - 1'b1);

    assign row_edge = (row_reg == '0) || (row_reg == CW'(SIDE - 1));
    assign col_edge = (col_reg == '0) || (col_reg == CW'(SIDE - 1));

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_LOAD:
            begin
                if (accept && load_last)
                begin
                    state_next = ST_READ;
                end
            end
            ST_READ:
            begin
                if (tap_last)
                begin
                    state_next = ST_WAIT;
                end
            end
            ST_WAIT: state_next = ST_DIV;
            ST_DIV:  state_next = ST_EMIT;
            ST_EMIT: state_next = pix_last ? ST_LOAD : ST_READ;
            default: state_next = ST_LOAD;
        endcase
    end

    always_comb
    begin
        load_cnt_next = load_cnt_reg;
        row_next      = row_reg;
        col_next      = col_reg;
        dr_next       = dr_reg;
        dc_next       = dc_reg;
        if ((state_reg == ST_LOAD) && accept)
        begin
            load_cnt_next = load_last ? '0 : load_cnt_reg + 1'b1;
        end
        if (state_reg == ST_READ)
        begin
            if (dc_reg == 2'd2)
            begin
                dc_next = '0;
                dr_next = (dr_reg == 2'd2) ? 2'd0 : dr_reg + 2'd1;
            end
            else
            begin
                dc_next = dc_reg + 2'd1;
            end
        end
        if (state_reg == ST_EMIT)
        begin
            if (col_reg == CW'(SIDE - 1))
            begin
                col_next = '0;
                row_next = (row_reg == CW'(SIDE - 1)) ? '0 : row_reg + 1'b1;
            end
            else
            begin
                col_next = col_reg + 1'b1;
            end
        end
    end

    // output decode
    always_comb
    begin
        busy     = (state_reg != ST_LOAD);
        rd_en    = (state_reg == ST_READ) && tap_inb;
        add_next = rd_en;
        valid    = (state_reg == ST_EMIT);
        last     = valid && pix_last;
        waddr    = load_cnt_reg;
        ctrl.clr = (state_reg == ST_READ) && (dr_reg == '0) && (dc_reg == '0);
        ctrl.add = add_reg;
        ctrl.mul = (state_reg == ST_DIV);
        priority if (row_edge && col_edge)
        begin
            ctrl.sel = DIV_BY_4;
        end
        else if (row_edge || col_edge)
        begin
            ctrl.sel = DIV_BY_6;
        end
        else
        begin
            ctrl.sel = DIV_BY_9;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_LOAD;
            load_cnt_reg <= '0;
            row_reg      <= '0;
            col_reg      <= '0;
            dr_reg       <= '0;
            dc_reg       <= '0;
            add_reg      <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            load_cnt_reg <= load_cnt_next;
            row_reg      <= row_next;
            col_reg      <= col_next;
            dr_reg       <= dr_next;
            dc_reg       <= dc_next;
            add_reg      <= add_next;
        end
    end

    `BMF_ASSERT_NEXT(a_image_starts, clk, rst_n, accept && load_last, (state_reg == ST_READ) && (row_reg == '0) && (col_reg == '0), "filter pass did not start at origin")
    `BMF_ASSERT_NEXT(a_image_ends, clk, rst_n, last, (state_reg == ST_LOAD) && (load_cnt_reg == '0), "no return to load after final result")
    `BMF_ASSERT_NEXT(a_window_restart, clk, rst_n, valid, (dr_reg == '0) && (dc_reg == '0), "window taps not rewound after result")
    `BMF_ASSERT_NOW(a_emit_after_div, clk, rst_n, valid, $past(state_reg == ST_DIV), "result strobe without multiply")

endmodule

`default_nettype wire

// ----- rtl/box_mean_filter_3x3_core.sv -----
`default_nettype none
// 3x3 box mean filter over a SIDE x SIDE image of unsigned 8-bit pixels.
//
// Input: a pixel transaction is taken on a rising edge with start high and
// busy low. Pixels arrive in raster order, one per cycle at most.
// Output: once the last pixel of an image is in, busy goes high and the
// block produces SIDE*SIDE means in raster order. Each is on mean_out
// (unsigned 8.8, truncated) for one cycle with valid high; last_out marks
// the final one. The receiver cannot stall, so nothing is held back.
//
// Sequence: loading takes SIDE*SIDE accepted pixels. Each mean then steps
// through the nine window taps one per cycle, reading the in-bounds ones
// from the pixel store, then takes the registered read data, then goes
// through the shared reciprocal multiplier, then presents the result.
// busy drops the cycle after last_out.
//
// Reset: returns to loading with an empty image. The pixel store needs no
// clearing: every read hits a pixel of the current image.
module box_mean_filter_3x3_core
    import bmf_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    output logic                   busy,
    input  wire logic [PIX_W-1:0]  pixel_in,
    output logic                   valid,
    output logic      [MEAN_W-1:0] mean_out,
    output logic                   last_out
);

    logic          accept;
    logic [AW-1:0] waddr;
    logic          rd_en;
    logic [AW-1:0] raddr;
    logic [PIX_W-1:0] rd_data;
    ctrl_t         ctrl;

    assign accept = start && !busy;

    bmf_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .accept (accept),
        .busy   (busy),
        .waddr  (waddr),
        .rd_en  (rd_en),
        .raddr  (raddr),
        .ctrl   (ctrl),
        .valid  (valid),
        .last   (last_out)
    );

    bmf_store u_store (
        .clk   (clk),
        .we    (accept),
        .waddr (waddr),
        .wdata (pixel_in),
        .re    (rd_en),
        .raddr (raddr),
        .rdata (rd_data)
    );

    bmf_mean_unit u_mean (
        .clk     (clk),
        .ctrl    (ctrl),
        .rd_data (rd_data),
        .mean    (mean_out)
    );

endmodule

`default_nettype wire

// ----- bench/box_mean_checker.sv -----
`timescale 1ns / 100ps

module box_mean_checker
    import bmf_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    input  wire logic              busy,
    input  wire logic [PIX_W-1:0]  pixel_in,
    input  wire logic              valid,
    input  wire logic [MEAN_W-1:0] mean_out,
    input  wire logic              last_out,
    output int                     errors,
    output int                     pending
);

    typedef struct packed {
        logic [MEAN_W-1:0] mean;
        logic              last;
    } mean_txn_t;

    logic [PIX_W-1:0] image [PIXELS];
    int               loaded = 0;
    mean_txn_t        expected_means [$];

    initial errors = 0;
    initial pending = 0;

    // Mean over the in-bounds part of the 3x3 window, floor(sum * 256 / cells).
    function automatic logic [MEAN_W-1:0] window_mean(input int r, input int c);
        int r0;
        int r1;
        int c0;
        int c1;
        int sum;
        int cells;
        r0 = (r > 0) ? r - 1 : r;
        r1 = (r + 1 < SIDE) ? r + 1 : r;
        c0 = (c > 0) ? c - 1 : c;
        c1 = (c + 1 < SIDE) ? c + 1 : c;
        sum = 0;
        for (int i = r0; i <= r1; i++)
            for (int j = c0; j <= c1; j++)
                sum += image[i * SIDE + j];
        cells = (r1 - r0 + 1) * (c1 - c0 + 1);
        return MEAN_W'((sum * 256) / cells);
    endfunction

    always @(posedge clk)
    begin : watch
        mean_txn_t want;
        if (rst_n)
        begin
            if (start === 1'b1 && busy === 1'b0)
            begin
                image[loaded] = pixel_in;
                loaded++;
                // image complete: whole frame of means is due, next pixel starts fresh
                if (loaded == PIXELS)
                begin
                    for (int r = 0; r < SIDE; r++)
                        for (int c = 0; c < SIDE; c++)
                        begin
                            want.mean = window_mean(r, c);
                            want.last = (r * SIDE + c == PIXELS - 1);
                            expected_means.push_back(want);
                        end
                    loaded = 0;
                end
            end
            if (valid === 1'b1)
            begin
                if (expected_means.size() == 0)
                begin
                    $display("%0t: unexpected result, expected none, actual mean %h last %b",
                             $time, mean_out, last_out);
                    errors++;
                end
                else
                begin
                    want = expected_means.pop_front();
                    if (mean_out !== want.mean)
                    begin
                        $display("%0t: mean_out mismatch, expected %h, actual %h",
                                 $time, want.mean, mean_out);
                        errors++;
                    end
                    if (last_out !== want.last)
                    begin
                        $display("%0t: last_out mismatch, expected %b, actual %b",
                                 $time, want.last, last_out);
                        errors++;
                    end
                end
            end
            pending = expected_means.size();
        end
    end

endmodule

// ----- bench/box_mean_filter_3x3_core_tb.sv -----
`timescale 1ns / 100ps

module box_mean_filter_3x3_core_tb;
    import bmf_pkg::*;

    localparam int IMAGES = 4;
    localparam int LIMIT  = 100000;

    // opening pixels of the first image: field extremes and single-bit patterns
    localparam logic [PIX_W-1:0] OPENING [24] = '{
        8'hFF, 8'h00, 8'hFF, 8'h00, 8'h55, 8'hAA, 8'h01, 8'h02,
        8'h04, 8'h08, 8'h10, 8'h20, 8'h40, 8'h80, 8'hFE, 8'hFD,
        8'hFB, 8'hF7, 8'hEF, 8'hDF, 8'hBF, 8'h7F, 8'hFF, 8'hFF
    };

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              start = 1'b0;
    logic [PIX_W-1:0]  pixel_in = '0;
    logic              busy;
    logic              valid;
    logic [MEAN_W-1:0] mean_out;
    logic              last_out;
    int                errors;
    int                pending;
    int                cycles = 0;
    bit                steady = 1'b0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    box_mean_filter_3x3_core DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .busy     (busy),
        .pixel_in (pixel_in),
        .valid    (valid),
        .mean_out (mean_out),
        .last_out (last_out)
    );

    box_mean_checker u_checker (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .busy     (busy),
        .pixel_in (pixel_in),
        .valid    (valid),
        .mean_out (mean_out),
        .last_out (last_out),
        .errors   (errors),
        .pending  (pending)
    );

    // 0: uniform, 1: mostly full scale, 2: only black and white
    function automatic logic [PIX_W-1:0] image_pixel(input int mode);
        if (mode == 1)
            return ($urandom_range(99) < 90) ? 8'hFF : PIX_W'($urandom);
        if (mode == 2)
            return $urandom_range(1) ? 8'hFF : 8'h00;
        return PIX_W'($urandom);
    endfunction

    // one pixel transaction; start stays high until busy lets it in
    task automatic send_pixel(input logic [PIX_W-1:0] px);
        while (!steady && $urandom_range(99) < 28)
        begin
            start    <= 1'b0;
            pixel_in <= PIX_W'($urandom);
            @(posedge clk);
        end
        start    <= 1'b1;
        pixel_in <= px;
        @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int img = 0; img < IMAGES; img++)
        begin
            steady = (img == 2);
            for (int k = 0; k < PIXELS; k++)
            begin
                if (img == 0 && k < 24)
                    send_pixel(OPENING[k]);
                else
                    send_pixel(image_pixel(img % 3));
            end
        end
        start <= 1'b0;
        steady = 1'b0;

        @(posedge clk);
        while (pending != 0 || busy)
            @(posedge clk);
        repeat (20) @(posedge clk);

        if (errors == 0 && pending == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
